// ----- rtl/core/dq_pkg.sv -----
// dq_pkg: operation codes, state encoding and constants for the double-ended queue
// no dependencies; used by double_ended_queue
`timescale 1ns / 1ps

package dq_pkg;

  // operation codes carried in op_i
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  // value reported for a missing element
  localparam logic signed [31:0] NoneValue = 32'shFFFFFFFF;

  // width of the occupancy field
  localparam int unsigned OccWidth = 11;

endpackage

// ----- rtl/core/dq_ram.sv -----
// dq_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies; instanced by double_ended_queue for the element store
`timescale 1ns / 1ps

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values held in a ring store in one RAM
// (one write port, one registered read port). Each transfer on the input channel is
// one operation: push front, push back, pop front, pop back or a query (unused op
// codes act as a query); each gives exactly one result with the popped value, the
// pop-on-empty and push-dropped flags, the front and back after the operation (-1
// when empty), the occupancy (low 11 bits) and an empty flag. Front and back are kept
// in registers, so pushes, queries and pops that empty the deque or find it empty give
// their result in the cycle after they are taken; a pop that leaves one or more entries
// passes through the read state first, since the new front or back must be fetched
// through the RAM read port. A new operation is taken in the cycle its predecessor's
// result is taken. No clearing pass is needed after reset.
// depends on dq_pkg and dq_ram
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] popped_o,
  output logic               pop_on_empty_o,
  output logic               push_dropped_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [10:0]        occupancy_o,
  output logic               is_empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // ring index helpers
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

  // ring state and cached end values
  dq_pkg::state_e      state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic signed [31:0]  front_q, front_d;
  logic signed [31:0]  back_q, back_d;
  logic                sel_back_q, sel_back_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic signed [31:0]  popped_q, popped_d;
  logic                pop_empty_q, pop_empty_d;
  logic                push_drop_q, push_drop_d;
  logic signed [31:0]  front_out_q, front_out_d;
  logic signed [31:0]  back_out_q, back_out_d;
  logic [CW-1:0]       occ_q, occ_d;

  // ram ports
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic signed [31:0]  ram_rdata;
  logic [31:0]         ram_rdata_raw;

  logic accept;
  logic is_full, is_empty;
  logic need_read;

  assign in_ready_o = (state_q == dq_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign ram_rdata  = $signed(ram_rdata_raw);

  // operation sequencing
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    sel_back_d  = sel_back_q;
    out_valid_d = out_valid_q && !out_ready_i;
    popped_d    = popped_q;
    pop_empty_d = pop_empty_q;
    push_drop_d = push_drop_q;
    front_out_d = front_out_q;
    back_out_d  = back_out_q;
    occ_d       = occ_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    need_read   = 1'b0;

    case (state_q)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          popped_d    = dq_pkg::NoneValue;
          pop_empty_d = 1'b0;
          push_drop_d = 1'b0;
          case (op_i)
            dq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                push_drop_d = 1'b1;
              end else begin
                head_d    = ring_dec(head_q);
                ram_we    = 1'b1;
                ram_waddr = ring_dec(head_q);
                count_d   = count_q + CW'(1);
                front_d   = value_i;
                if (is_empty) begin
                  back_d = value_i;
                end
              end
            end
            dq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                push_drop_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head_q, count_q);
                count_d   = count_q + CW'(1);
                back_d    = value_i;
                if (is_empty) begin
                  front_d = value_i;
                end
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                pop_empty_d = 1'b1;
              end else begin
                popped_d = front_q;
                head_d   = ring_inc(head_q);
                count_d  = count_q - CW'(1);
                if (count_q > CW'(1)) begin
                  need_read  = 1'b1;
                  ram_re     = 1'b1;
                  ram_raddr  = ring_inc(head_q);
                  sel_back_d = 1'b0;
                end
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                pop_empty_d = 1'b1;
              end else begin
                popped_d = back_q;
                count_d  = count_q - CW'(1);
                if (count_q > CW'(1)) begin
                  need_read  = 1'b1;
                  ram_re     = 1'b1;
                  ram_raddr  = ring_add(head_q, count_q - CW'(2));
                  sel_back_d = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          occ_d       = count_d;
          front_out_d = (count_d == '0) ? dq_pkg::NoneValue : front_d;
          back_out_d  = (count_d == '0) ? dq_pkg::NoneValue : back_d;
          out_valid_d = !need_read;
          state_d     = need_read ? dq_pkg::ST_READ : dq_pkg::ST_IDLE;
        end
      end
      dq_pkg::ST_READ: begin
        // fetched entry becomes the new front or back
        if (sel_back_q) begin
          back_d     = ram_rdata;
          back_out_d = ram_rdata;
        end else begin
          front_d     = ram_rdata;
          front_out_d = ram_rdata;
        end
        out_valid_d = 1'b1;
        state_d     = dq_pkg::ST_IDLE;
      end
      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    back_q      <= back_d;
    sel_back_q  <= sel_back_d;
    popped_q    <= popped_d;
    pop_empty_q <= pop_empty_d;
    push_drop_q <= push_drop_d;
    front_out_q <= front_out_d;
    back_out_q  <= back_out_d;
    occ_q       <= occ_d;
  end

  // element store
  dq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // result outputs
  assign out_valid_o    = out_valid_q;
  assign popped_o       = popped_q;
  assign pop_on_empty_o = pop_empty_q;
  assign push_dropped_o = push_drop_q;
  assign front_value_o  = front_out_q;
  assign back_value_o   = back_out_q;
  assign occupancy_o    = dq_pkg::OccWidth'(occ_q);
  assign is_empty_o     = (occ_q == '0);

`ifndef NO_ASSERTIONS
  // occupancy never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("held count beyond capacity");

  // head stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= AW'(DEPTH - 1))
    else $error("head index outside ring");

  // result slot is free while a fetch is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == dq_pkg::ST_READ) |-> !out_valid_q)
    else $error("result pending during fetch");

  // a fetch follows only an accepted pop that left one or more entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == dq_pkg::ST_READ) |-> ($past(accept) && count_q != '0))
    else $error("fetch without a pop");

  // store is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("store write and read collide");
`endif

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for double_ended_queue, driven with random and directed operations
// depends on dq_pkg and the double_ended_queue rtl; carries its own deque predictor
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam int SINK_HOLD   = 300;
  localparam int SETTLE      = 4;
  localparam int MIX_LEN     = 30;

  // op codes the block treats as a plain query
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  typedef struct {
    logic signed [31:0] popped;
    logic               pop_on_empty;
    logic               push_dropped;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [10:0]        occupancy;
    logic               is_empty;
  } dq_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         op_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] popped_o;
  logic               pop_on_empty_o;
  logic               push_dropped_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] back_value_o;
  logic [10:0]        occupancy_o;
  logic               is_empty_o;

  // predictor state: ring store, front index and count
  logic signed [31:0] deque_mem [DEPTH];
  logic [9:0]         deque_head = '0;
  int                 deque_count = 0;

  dq_result_t expected_q[$];

  // bench bookkeeping
  int errors       = 0;
  int ops_sent     = 0;
  int results_seen = 0;
  int empty_pops   = 0;
  int full_pushes  = 0;
  int peak_count   = 0;
  int holds_done   = 0;
  int quiet_cycles = 0;
  int sink_hold    = 0;
  bit pace_on      = 1'b1;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .popped_o      (popped_o),
    .pop_on_empty_o(pop_on_empty_o),
    .push_dropped_o(push_dropped_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .occupancy_o   (occupancy_o),
    .is_empty_o    (is_empty_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one operation to the deque copy and return the result it should give
  function automatic dq_result_t apply_op(input logic [2:0] op, input logic signed [31:0] val);
    dq_result_t r;
    logic [9:0] tail;
    r.popped       = dq_pkg::NoneValue;
    r.pop_on_empty = 1'b0;
    r.push_dropped = 1'b0;
    case (op)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          r.push_dropped = 1'b1;
        end else if (op == dq_pkg::OP_PUSH_FRONT) begin
          deque_head = deque_head - 10'd1;
          deque_mem[deque_head] = val;
          deque_count++;
        end else begin
          tail = deque_head + 10'(deque_count);
          deque_mem[tail] = val;
          deque_count++;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (deque_count == 0) begin
          r.pop_on_empty = 1'b1;
        end else if (op == dq_pkg::OP_POP_FRONT) begin
          r.popped = deque_mem[deque_head];
          deque_head = deque_head + 10'd1;
          deque_count--;
        end else begin
          tail = deque_head + 10'(deque_count - 1);
          r.popped = deque_mem[tail];
          deque_count--;
        end
      end
      default: ;
    endcase
    if (deque_count != 0) begin
      r.front_value = deque_mem[deque_head];
      r.back_value  = deque_mem[deque_head + 10'(deque_count - 1)];
    end else begin
      r.front_value = dq_pkg::NoneValue;
      r.back_value  = dq_pkg::NoneValue;
    end
    r.occupancy = 11'(deque_count);
    r.is_empty  = (deque_count == 0);
    return r;
  endfunction

  // one line per mismatch
  task automatic flag_error(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
  endtask

  task automatic compare_result(input dq_result_t want);
    check_field("popped", popped_o, want.popped);
    check_field("pop_on_empty", 32'(pop_on_empty_o), 32'(want.pop_on_empty));
    check_field("push_dropped", 32'(push_dropped_o), 32'(want.push_dropped));
    check_field("front_value", front_value_o, want.front_value);
    check_field("back_value", back_value_o, want.back_value);
    check_field("occupancy", 32'(occupancy_o), 32'(want.occupancy));
    check_field("is_empty", 32'(is_empty_o), 32'(want.is_empty));
  endtask

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin : monitor
    dq_result_t want;
    bit moved;
    moved = 1'b0;
    if (in_valid_i && in_ready_o) begin
      want = apply_op(op_i, value_i);
      expected_q.insert(expected_q.size(), want);
      if (want.pop_on_empty) empty_pops++;
      if (want.push_dropped) full_pushes++;
      if (deque_count > peak_count) peak_count = deque_count;
      moved = 1'b1;
    end
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        compare_result(want);
      end
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb: no transfer for %0d cycles, giving up", STALL_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // result side: random ready gaps, plus a long hold when a test asks for one
  initial begin : result_sink
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (sink_hold - 1) @(negedge clk_i);
        sink_hold = 0;
        holds_done++;
      end
      gap = pace_on ? $urandom_range(0, 13) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // offer one operation and wait for its transfer
  task automatic send_op(input logic [2:0] op, input logic signed [31:0] val);
    int gap;
    gap = pace_on ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i       = op;
    value_i    = val;
    ops_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_settled();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // value mix with the extremes weighted up
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // op mix leaning toward growth or toward draining
  function automatic logic [2:0] pick_op(input bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 95) begin
      case ($urandom_range(0, 2))
        0:       return OP_RSVD_LO;
        1:       return OP_RSVD_MID;
        default: return OP_RSVD_HI;
      endcase
    end
    if (r >= 84) return dq_pkg::OP_QUERY;
    if (grow) begin
      if (r < 30) return dq_pkg::OP_PUSH_FRONT;
      if (r < 60) return dq_pkg::OP_PUSH_BACK;
      if (r < 72) return dq_pkg::OP_POP_FRONT;
      return dq_pkg::OP_POP_BACK;
    end
    if (r < 12) return dq_pkg::OP_PUSH_FRONT;
    if (r < 24) return dq_pkg::OP_PUSH_BACK;
    if (r < 54) return dq_pkg::OP_POP_FRONT;
    return dq_pkg::OP_POP_BACK;
  endfunction

  // empty-deque cases, extreme values, every op code, single-entry pops
  task automatic test_directed();
    send_op(dq_pkg::OP_QUERY, 32'sd0);
    send_op(dq_pkg::OP_POP_FRONT, 32'sd0);
    send_op(dq_pkg::OP_POP_BACK, 32'sd0);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_op(dq_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_op(dq_pkg::OP_QUERY, 32'sh1234_5678);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'sd0);
    send_op(dq_pkg::OP_PUSH_BACK, 32'shFFFF_FFFF);
    send_op(dq_pkg::OP_PUSH_BACK, 32'sh5555_5555);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
    send_op(OP_RSVD_LO, 32'sh7FFF_FFFF);
    send_op(OP_RSVD_MID, 32'sh8000_0000);
    send_op(OP_RSVD_HI, 32'shFFFF_FFFF);
    send_op(dq_pkg::OP_POP_FRONT, 32'sd7);
    send_op(dq_pkg::OP_POP_BACK, 32'sd7);
    send_op(dq_pkg::OP_POP_FRONT, 32'sd0);
    send_op(dq_pkg::OP_POP_BACK, 32'sd0);
    send_op(dq_pkg::OP_POP_FRONT, 32'sd0);
    send_op(dq_pkg::OP_POP_BACK, 32'sd0);
    send_op(dq_pkg::OP_POP_FRONT, 32'sd0);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'sh0F0F_0F0F);
    send_op(dq_pkg::OP_POP_BACK, 32'sd0);
    send_op(dq_pkg::OP_PUSH_BACK, 32'shF0F0_F0F0);
    send_op(dq_pkg::OP_POP_FRONT, 32'sd0);
    wait_settled();
  endtask

  // random segments alternating growth and draining, pacing on or off per segment
  task automatic test_random_mix(input int segs);
    for (int seg = 0; seg < segs; seg++) begin
      pace_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < MIX_LEN; i++) send_op(pick_op(seg % 2 == 0), rand_value());
    end
    pace_on = 1'b1;
    wait_settled();
  endtask

  // fill to capacity under a long receiver hold, then push into full and pop near full
  task automatic test_fill_to_capacity();
    int room;
    room = DEPTH - deque_count;
    pace_on = 1'b0;
    sink_hold = SINK_HOLD;
    for (int i = 0; i < room; i++) begin
      if (i % 256 == 128) pace_on = ~pace_on;
      send_op($urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
              rand_value());
    end
    pace_on = 1'b1;
    send_op(dq_pkg::OP_PUSH_FRONT, rand_value());
    send_op(dq_pkg::OP_PUSH_BACK, rand_value());
    send_op(dq_pkg::OP_QUERY, rand_value());
    send_op(dq_pkg::OP_POP_FRONT, rand_value());
    send_op(dq_pkg::OP_POP_BACK, rand_value());
    send_op(dq_pkg::OP_PUSH_FRONT, rand_value());
    send_op(dq_pkg::OP_PUSH_BACK, rand_value());
    send_op(dq_pkg::OP_PUSH_BACK, rand_value());
    wait_settled();
  endtask

  // main sequence
  initial begin : main
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = dq_pkg::OP_QUERY;
    value_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_mix(2);
    test_fill_to_capacity();

    $display("tb: %0d operations sent, %0d results checked, peak occupancy %0d",
             ops_sent, results_seen, peak_count);
    $display("tb: %0d pops on empty, %0d pushes into full, %0d long output holds",
             empty_pops, full_pushes, holds_done);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
